@@ rtl/ezm_pkg.sv @@
// Package for the Euler ZYX model matrix block: formats, CORDIC constants,
// pipeline latencies and the rounding product helpers. No dependencies.
`default_nettype none
package ezm_pkg;

  localparam int TRIG_FRACTION_BITS = 16;
  localparam int TW        = TRIG_FRACTION_BITS + 2;   // trig value width
  localparam int RW        = TW + 1;                   // rotation entry width
  localparam int SH_TRIG   = 30 - TRIG_FRACTION_BITS;
  localparam int SH_SCALE  = TRIG_FRACTION_BITS - 8;

  localparam int CORDIC_STEPS = 24;
  localparam int XW = 34;                              // CORDIC x/y width, Q2.30 plus guard
  localparam int ZW = 32;                              // residual angle, 2^-20 degree
  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
  localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [16:0] HALF_TURN    = 17'sd23040;

  localparam int LAT_CORDIC = CORDIC_STEPS + 2;
  localparam int LAT_MATRIX = 3;
  localparam int LAT_TOTAL  = LAT_CORDIC + LAT_MATRIX;

  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [RW-1:0] rot_t;
  typedef logic signed [31:0]   q16_t;
  typedef logic signed [15:0]   q8_t;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121, 32'sd3750058,
    32'sd1876857, 32'sd938658, 32'sd469357, 32'sd234682, 32'sd117342,
    32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29, 32'sd14, 32'sd7
  };

  // Product of two trig values, rounded half up back to the trig format.
  function automatic trig_t mulq(input trig_t a, input trig_t b);
    logic signed [2*TW-1:0] p;
    p = (2*TW)'(a) * (2*TW)'(b);
    p = p + ((2*TW)'(1) <<< (TRIG_FRACTION_BITS - 1));
    p = p >>> TRIG_FRACTION_BITS;
    return p[TW-1:0];
  endfunction

  // Rotation entry times a Q8.8 scale, rounded to Q16.16 and saturated.
  function automatic q16_t scaled(input rot_t r, input q8_t s);
    logic signed [RW+15:0] p;
    p = (RW+16)'(r) * (RW+16)'(s);
    p = p + ((RW+16)'(1) <<< (SH_SCALE - 1));
    p = p >>> SH_SCALE;
    if (p > (RW+16)'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (p < -(RW+16)'(33'sh80000000)) return 32'sh80000000;
    return p[31:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/ezm_if.sv @@
// Channel interfaces for the model matrix block: parameter beats in,
// matrix beats out. Depends on ezm_pkg.
`default_nettype none
interface ezm_in_if;
  import ezm_pkg::*;
  logic valid;
  logic ready;
  q8_t  angle_x, angle_y, angle_z;
  q8_t  scale_x, scale_y, scale_z;
  q16_t pos_x, pos_y, pos_z;
  modport source (output valid, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
                  pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
                  pos_x, pos_y, pos_z, output ready);
endinterface

interface ezm_out_if;
  import ezm_pkg::*;
  logic valid;
  logic ready;
  q16_t m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23;
  modport source (output valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, input ready);
  modport sink   (input valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, output ready);
endinterface
`default_nettype wire

@@ rtl/ezm_cordic.sv @@
// Pipelined degree CORDIC: one angle in, sine and cosine out, with every
// stage advancing only on enabled cycles. Depends on ezm_pkg.
`default_nettype none
module ezm_cordic (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire ezm_pkg::q8_t   angle,
  output ezm_pkg::trig_t      sin_o,
  output ezm_pkg::trig_t      cos_o
);
  import ezm_pkg::*;

  localparam logic signed [XW:0] ONE = (XW+1)'(1) <<< TRIG_FRACTION_BITS;

  logic signed [XW-1:0] x [CORDIC_STEPS+1];
  logic signed [XW-1:0] y [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z [CORDIC_STEPS+1];
  logic                 fl [CORDIC_STEPS+1];
  logic signed [16:0]   a_ext;
  logic signed [16:0]   a_red;
  logic                 flip;

  // Fold into [-90, +90] degrees.
  always_comb begin
    a_ext = 17'(angle);
    a_red = a_ext;
    flip  = 1'b0;
    if (a_ext > QUARTER_TURN) begin
      a_red = a_ext - HALF_TURN;
      flip  = 1'b1;
    end else if (a_ext < -QUARTER_TURN) begin
      a_red = a_ext + HALF_TURN;
      flip  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= CORDIC_GAIN;
      y[0]  <= '0;
      z[0]  <= ZW'(a_red) <<< 13;
      fl[0] <= flip;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_TAB[i];
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  function automatic trig_t to_trig(input logic signed [XW-1:0] v, input logic neg);
    logic signed [XW:0] q;
    q = neg ? -(XW+1)'(v) : (XW+1)'(v);
    q = (q + ((XW+1)'(1) <<< (SH_TRIG - 1))) >>> SH_TRIG;
    if (q > ONE) q = ONE;
    if (q < -ONE) q = -ONE;
    return q[TW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= to_trig(x[CORDIC_STEPS], fl[CORDIC_STEPS]);
      sin_o <= to_trig(y[CORDIC_STEPS], fl[CORDIC_STEPS]);
    end
  end
endmodule
`default_nettype wire

@@ rtl/ezm_matrix.sv @@
// Three-stage matrix build: pair products, triple products and sums,
// then column scaling with saturation. Depends on ezm_pkg.
`default_nettype none
module ezm_matrix (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire ezm_pkg::trig_t s1, c1, s2, c2, s3, c3,
  input  wire ezm_pkg::q8_t   sx, sy, sz,
  output ezm_pkg::q16_t       m00, m01, m02, m10, m11, m12, m20, m21, m22
);
  import ezm_pkg::*;

  trig_t p_c1c2, p_c1s2, p_c3s1, p_s1s3, p_c1c3, p_s1s2, p_c2s1, p_c2s3, p_c2c3;
  trig_t p_c1s3;
  trig_t n_s2, d_s2, d_s3;
  rot_t  r00, r01, r02, r10, r11, r12, r20, r21, r22;
  q8_t   sx1, sy1, sz1, sx2, sy2, sz2;

  always_ff @(posedge clk) begin
    if (en) begin
      p_c1c2 <= mulq(c1, c2);
      p_c1s2 <= mulq(c1, s2);
      p_c3s1 <= mulq(c3, s1);
      p_s1s3 <= mulq(s1, s3);
      p_c1c3 <= mulq(c1, c3);
      p_s1s2 <= mulq(s1, s2);
      p_c2s1 <= mulq(c2, s1);
      p_c2s3 <= mulq(c2, s3);
      p_c2c3 <= mulq(c2, c3);
      p_c1s3 <= mulq(c1, s3);
      n_s2   <= -s2;
      d_s2   <= s2;
      d_s3   <= s3;
      sx1 <= sx; sy1 <= sy; sz1 <= sz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r00 <= RW'(p_c1c2);
      r01 <= RW'(mulq(p_c1s2, d_s3)) - RW'(p_c3s1);
      r02 <= RW'(p_s1s3) + RW'(mulq(p_c1c3, d_s2));
      r10 <= RW'(p_c2s1);
      r11 <= RW'(p_c1c3) + RW'(mulq(p_s1s2, d_s3));
      r12 <= RW'(mulq(p_c3s1, d_s2)) - RW'(p_c1s3);
      r20 <= RW'(n_s2);
      r21 <= RW'(p_c2s3);
      r22 <= RW'(p_c2c3);
      sx2 <= sx1; sy2 <= sy1; sz2 <= sz1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m00 <= scaled(r00, sx2);
      m01 <= scaled(r01, sy2);
      m02 <= scaled(r02, sz2);
      m10 <= scaled(r10, sx2);
      m11 <= scaled(r11, sy2);
      m12 <= scaled(r12, sz2);
      m20 <= scaled(r20, sx2);
      m21 <= scaled(r21, sy2);
      m22 <= scaled(r22, sz2);
    end
  end
endmodule
`default_nettype wire

@@ rtl/euler_zyx_model_matrix.sv @@
// Top level of the Euler ZYX model matrix block. Depends on ezm_pkg,
// ezm_if, ezm_cordic and ezm_matrix.
//
// Turns three Euler angles (1/128 degree), three Q8.8 column scales and a
// Q16.16 position into the top three rows of M = [Rz*Ry*Rx*diag(s) | p],
// entries in Q16.16 with saturation. The block is a pipeline of 29 register
// stages: one angle fold stage, 24 CORDIC step stages and one rounding stage
// per angle (three CORDIC units side by side), then pair products, triple
// products with sums, and column scaling. It takes one beat per cycle unless
// stalled: the whole pipeline holds while a finished result waits at the
// output, and in_ch.ready is simply "output register empty or being taken".
`default_nettype none
module euler_zyx_model_matrix (
  input  wire logic clk,
  input  wire logic rst,
  ezm_in_if.sink    in_ch,
  ezm_out_if.source out_ch
);
  import ezm_pkg::*;

  logic en;
  logic vld [LAT_TOTAL];
  q8_t  scx [LAT_CORDIC], scy [LAT_CORDIC], scz [LAT_CORDIC];
  q16_t psx [LAT_TOTAL], psy [LAT_TOTAL], psz [LAT_TOTAL];
  trig_t s1, c1, s2, c2, s3, c3;

  // Advance everything unless the output beat is stalled.
  assign en          = !vld[LAT_TOTAL-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[LAT_TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT_TOTAL; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_ch.valid;
      for (int i = 1; i < LAT_TOTAL; i++) vld[i] <= vld[i-1];
    end
  end

  // Carry scales and position alongside the trig pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      scx[0] <= in_ch.scale_x; scy[0] <= in_ch.scale_y; scz[0] <= in_ch.scale_z;
      for (int i = 1; i < LAT_CORDIC; i++) begin
        scx[i] <= scx[i-1]; scy[i] <= scy[i-1]; scz[i] <= scz[i-1];
      end
      psx[0] <= in_ch.pos_x; psy[0] <= in_ch.pos_y; psz[0] <= in_ch.pos_z;
      for (int i = 1; i < LAT_TOTAL; i++) begin
        psx[i] <= psx[i-1]; psy[i] <= psy[i-1]; psz[i] <= psz[i-1];
      end
    end
  end

  ezm_cordic u_cordic_z (.clk, .en, .angle(in_ch.angle_z), .sin_o(s1), .cos_o(c1));
  ezm_cordic u_cordic_y (.clk, .en, .angle(in_ch.angle_y), .sin_o(s2), .cos_o(c2));
  ezm_cordic u_cordic_x (.clk, .en, .angle(in_ch.angle_x), .sin_o(s3), .cos_o(c3));

  ezm_matrix u_matrix (
    .clk, .en,
    .s1, .c1, .s2, .c2, .s3, .c3,
    .sx(scx[LAT_CORDIC-1]), .sy(scy[LAT_CORDIC-1]), .sz(scz[LAT_CORDIC-1]),
    .m00(out_ch.m00), .m01(out_ch.m01), .m02(out_ch.m02),
    .m10(out_ch.m10), .m11(out_ch.m11), .m12(out_ch.m12),
    .m20(out_ch.m20), .m21(out_ch.m21), .m22(out_ch.m22)
  );

  assign out_ch.m03 = psx[LAT_TOTAL-1];
  assign out_ch.m13 = psy[LAT_TOTAL-1];
  assign out_ch.m23 = psz[LAT_TOTAL-1];
endmodule
`default_nettype wire

@@ rtl/ezm_checker.sv @@
// Port-level checks for the model matrix block and the bind that attaches
// them. Depends on ezm_pkg and euler_zyx_model_matrix.
`default_nettype none
module ezm_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire ezm_pkg::q16_t m00,
  input wire ezm_pkg::q16_t m03
);
  // Hold a stalled output beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m03))
    else $error("stalled output beat changed");

  // Accept input exactly when the output stage can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // Drop all beats on reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind euler_zyx_model_matrix ezm_checker u_ezm_checker (
  .clk(clk), .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .m00(out_ch.m00), .m03(out_ch.m03)
);
`default_nettype wire

@@ dv/euler_zyx_model_matrix_tb.sv @@
// Testbench for euler_zyx_model_matrix: drives parameter beats, predicts each
// model matrix in fixed point and checks every result beat in order.
// Depends on ezm_pkg and ezm_if from the RTL.
`timescale 1ns / 1ps
module euler_zyx_model_matrix_tb;
  import ezm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int QUIET_TAIL   = 250;   // last beats sent with no idling
  localparam int RAND_ITEMS   = 1930;
  localparam int LONG_HOLD    = 400;   // receiver hold-off, cycles
  localparam int LONG_HOLD_AT = 600;   // results seen before the hold-off

  typedef struct {
    q8_t  ax, ay, az;
    q8_t  sx, sy, sz;
    q16_t px, py, pz;
    bit   drain_first;  // wait for every result before offering this beat
  } params_t;

  typedef struct {
    q16_t m [12];
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ezm_in_if  in_ch ();
  ezm_out_if out_ch ();

  euler_zyx_model_matrix dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  params_t pending_params [$];
  matrix_t expected_matrices [$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: CORDIC sine/cosine in degrees, then the ZYX product.
  // ---------------------------------------------------------------------
  function automatic longint clamp_trig(input longint q30);
    longint r;
    longint one;
    one = longint'(1) <<< TRIG_FRACTION_BITS;
    r = (q30 + (longint'(1) <<< (SH_TRIG - 1))) >>> SH_TRIG;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r;
  endfunction

  task automatic sin_cos_deg(input q8_t ang, output longint s, output longint c);
    longint a, x, y, z, nx;
    bit     flip;
    a = ang;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    // Fold into [-90, +90] degrees; both outputs change sign.
    if (a > 11520) begin
      a -= 23040;
      flip = 1'b1;
    end else if (a < -11520) begin
      a += 23040;
      flip = 1'b1;
    end
    z = a * 8192;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    c = clamp_trig(flip ? -x : x);
    s = clamp_trig(flip ? -y : y);
  endtask

  function automatic longint trig_mul(input longint a, input longint b);
    return (a * b + (longint'(1) <<< (TRIG_FRACTION_BITS - 1))) >>> TRIG_FRACTION_BITS;
  endfunction

  function automatic q16_t col_scale(input longint r, input q8_t s);
    longint v;
    v = (r * longint'(s) + (longint'(1) <<< (SH_SCALE - 1))) >>> SH_SCALE;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_matrix(input params_t p, output matrix_t e);
    longint s1, c1, s2, c2, s3, c3;
    sin_cos_deg(p.az, s1, c1);
    sin_cos_deg(p.ay, s2, c2);
    sin_cos_deg(p.ax, s3, c3);
    e.m[0]  = col_scale(trig_mul(c1, c2), p.sx);
    e.m[1]  = col_scale(trig_mul(trig_mul(c1, s2), s3) - trig_mul(c3, s1), p.sy);
    e.m[2]  = col_scale(trig_mul(s1, s3) + trig_mul(trig_mul(c1, c3), s2), p.sz);
    e.m[3]  = p.px;
    e.m[4]  = col_scale(trig_mul(c2, s1), p.sx);
    e.m[5]  = col_scale(trig_mul(c1, c3) + trig_mul(trig_mul(s1, s2), s3), p.sy);
    e.m[6]  = col_scale(trig_mul(trig_mul(c3, s1), s2) - trig_mul(c1, s3), p.sz);
    e.m[7]  = p.py;
    e.m[8]  = col_scale(-s2, p.sx);
    e.m[9]  = col_scale(trig_mul(c2, s3), p.sy);
    e.m[10] = col_scale(trig_mul(c2, c3), p.sz);
    e.m[11] = p.pz;
  endtask

  task automatic report_mismatch(input int idx, input q16_t got, input q16_t want);
    mismatches++;
    $display("MISMATCH result %0d entry %0d: got %h expected %h",
             results_seen, idx, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic q8_t rand_angle();
    // Favour the fold boundaries now and then.
    case ($urandom_range(0, 5))
      0: return q8_t'(11520 + $urandom_range(0, 4) - 2);
      1: return q8_t'(-11520 + $urandom_range(0, 4) - 2);
      2: return q8_t'($urandom_range(0, 46080) - 23040);
      default: return q8_t'($urandom);
    endcase
  endfunction

  function automatic params_t rand_params();
    params_t p;
    p.ax = rand_angle();
    p.ay = rand_angle();
    p.az = rand_angle();
    p.sx = ($urandom_range(0, 3) == 0) ? q8_t'($urandom_range(0, 512) - 256) : q8_t'($urandom);
    p.sy = ($urandom_range(0, 3) == 0) ? q8_t'($urandom_range(0, 512) - 256) : q8_t'($urandom);
    p.sz = ($urandom_range(0, 3) == 0) ? q8_t'($urandom_range(0, 512) - 256) : q8_t'($urandom);
    p.px = $urandom;
    p.py = $urandom;
    p.pz = $urandom;
    p.drain_first = 1'b0;
    return p;
  endfunction

  function automatic params_t make_params(input int a1, a2, a3, s1, s2, s3,
                                          input q16_t t);
    params_t p;
    p.ax = q8_t'(a1); p.ay = q8_t'(a2); p.az = q8_t'(a3);
    p.sx = q8_t'(s1); p.sy = q8_t'(s2); p.sz = q8_t'(s3);
    p.px = t; p.py = ~t; p.pz = t ^ 32'h5A5A_A5A5;
    p.drain_first = 1'b0;
    return p;
  endfunction

  initial begin
    params_t p;
    // Directed: zero, unit scale, fold edges, angle extremes, scale extremes
    // (saturation) and position extremes.
    pending_params.push_back(make_params(0, 0, 0, 256, 256, 256, 32'h0));
    pending_params.push_back(make_params(11520, 11520, 11520, 256, 256, 256, 32'h7FFF_FFFF));
    pending_params.push_back(make_params(11521, 11521, 11521, 256, 256, 256, 32'h8000_0000));
    pending_params.push_back(make_params(-11520, -11520, -11520, 256, 256, 256, 32'hFFFF_FFFF));
    pending_params.push_back(make_params(-11521, -11521, -11521, 256, 256, 256, 32'h1));
    pending_params.push_back(make_params(23040, -23040, 23040, 256, 256, 256, 32'h0001_0000));
    pending_params.push_back(make_params(32767, 32767, 32767, 32767, 32767, 32767, 32'h7FFF_FFFF));
    pending_params.push_back(make_params(-32768, -32768, -32768, -32768, -32768, -32768,
                                         32'h8000_0000));
    pending_params.push_back(make_params(32767, -32768, 0, -32768, 32767, 0, 32'h1234_5678));
    pending_params.push_back(make_params(5760, 5760, 5760, 32767, -32768, 32767, 32'hDEAD_BEEF));
    pending_params.push_back(make_params(0, 0, 0, 32767, 32767, 32767, 32'h0));
    pending_params.push_back(make_params(0, 0, 0, -32768, -32768, -32768, 32'h0));
    pending_params.push_back(make_params(-5760, 17280, -17280, 1, -1, 0, 32'hFFFF_0000));
    pending_params.push_back(make_params(1, -1, 1, 256, -256, 256, 32'h0000_FFFF));
    pending_params.push_back(make_params(11519, -11519, 23039, 128, -128, 512, 32'hAAAA_5555));
    for (int i = 0; i < RAND_ITEMS; i++) begin
      p = rand_params();
      // Sender pause until the pipeline has fully drained.
      if (i == 300 || i == 1200) p.drain_first = 1'b1;
      pending_params.push_back(p);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Driver: offer the next beat once the current one has been taken.
  // ---------------------------------------------------------------------
  int in_idle = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.angle_x = '0; in_ch.angle_y = '0; in_ch.angle_z = '0;
    in_ch.scale_x = '0; in_ch.scale_y = '0; in_ch.scale_z = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
  end

  always @(posedge clk) begin
    params_t cur, nxt;
    matrix_t e;
    bit      taken;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      taken = in_ch.valid && in_ch.ready;
      if (taken) begin
        cur.ax = in_ch.angle_x; cur.ay = in_ch.angle_y; cur.az = in_ch.angle_z;
        cur.sx = in_ch.scale_x; cur.sy = in_ch.scale_y; cur.sz = in_ch.scale_z;
        cur.px = in_ch.pos_x;   cur.py = in_ch.pos_y;   cur.pz = in_ch.pos_z;
        predict_matrix(cur, e);
        expected_matrices.push_back(e);
      end
      if (!in_ch.valid || taken) begin
        if (in_idle > 0) begin
          in_idle--;
          in_ch.valid <= 1'b0;
        end else if (pending_params.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (pending_params[0].drain_first &&
                     (expected_matrices.size() != 0 || taken)) begin
          // Hold off until every result is back.
          in_ch.valid <= 1'b0;
        end else begin
          nxt = pending_params.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.angle_x <= nxt.ax; in_ch.angle_y <= nxt.ay; in_ch.angle_z <= nxt.az;
          in_ch.scale_x <= nxt.sx; in_ch.scale_y <= nxt.sy; in_ch.scale_z <= nxt.sz;
          in_ch.pos_x   <= nxt.px; in_ch.pos_y   <= nxt.py; in_ch.pos_z   <= nxt.pz;
          if (pending_params.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            in_idle = $urandom_range(1, 15);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver ready: random stall bursts plus one long hold-off, so the
  // pipeline fills and back-pressures the input.
  // ---------------------------------------------------------------------
  int  out_stall = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (pending_params.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
        out_stall = $urandom_range(1, 15);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    matrix_t want;
    q16_t    got [12];
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m03,
              out_ch.m10, out_ch.m11, out_ch.m12, out_ch.m13,
              out_ch.m20, out_ch.m21, out_ch.m22, out_ch.m23};
      if (expected_matrices.size() == 0) begin
        mismatches++;
        $display("UNEXPECTED result beat %0d", results_seen);
      end else begin
        want = expected_matrices.pop_front();
        for (int i = 0; i < 12; i++)
          if (got[i] !== want.m[i]) report_mismatch(i, got[i], want.m[i]);
      end
      results_seen++;
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // End of run: drain, let the pipeline settle, then judge.
  initial begin
    @(negedge rst);
    wait (pending_params.size() == 0 && !in_ch.valid && expected_matrices.size() == 0);
    repeat (LAT_TOTAL + 20) @(posedge clk);
    if (mismatches == 0 && expected_matrices.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (expected_matrices.size() != 0)
        $display("MISSING %0d result beats", expected_matrices.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
